/* design/assert_macros.svh */
// assertion macros used by the sgr_back filter module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* design/sgr_pkg.sv */
// types and constants of the sgr stream filter
package sgr_pkg;

	// characters
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_OPEN  = 8'd91;
	localparam logic [7:0] CH_END   = 8'd109;
	localparam logic [7:0] CH_SEP   = 8'd59;
	localparam logic [7:0] DIGIT_LO = 8'd48;
	localparam logic [7:0] DIGIT_HI = 8'd57;

	// parameter accumulator
	localparam int ACC_W = 10;
	localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;

	// sgr codes
	localparam logic [ACC_W-1:0] SGR_RESET     = 10'd0;
	localparam logic [ACC_W-1:0] SGR_BOLD      = 10'd1;
	localparam logic [ACC_W-1:0] SGR_FAINT     = 10'd2;
	localparam logic [ACC_W-1:0] SGR_ITALIC    = 10'd3;
	localparam logic [ACC_W-1:0] SGR_ULINE     = 10'd4;
	localparam logic [ACC_W-1:0] SGR_NORMAL    = 10'd22;
	localparam logic [ACC_W-1:0] SGR_NO_ITALIC = 10'd23;
	localparam logic [ACC_W-1:0] SGR_NO_ULINE  = 10'd24;
	localparam logic [ACC_W-1:0] SGR_FG_LO     = 10'd30;
	localparam logic [ACC_W-1:0] SGR_FG_HI     = 10'd37;
	localparam logic [ACC_W-1:0] SGR_BG_LO     = 10'd40;
	localparam logic [ACC_W-1:0] SGR_BG_HI     = 10'd47;

	// font weight codes
	localparam logic [1:0] WEIGHT_NORMAL = 2'd0;
	localparam logic [1:0] WEIGHT_BOLD   = 2'd1;
	localparam logic [1:0] WEIGHT_FAINT  = 2'd2;

	// configuration
	localparam logic [7:0] MAX_ESC_LEN_RESET = 8'd20;
	localparam logic       REG_MAX_ESC_LEN   = 1'b0;

	// queue between front and back
	localparam int SGR_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_PARAMS
	} phase_t;

	// one classified request from front to back
	typedef struct packed {
		logic             char_valid;
		logic [6:0]       ch;
		logic             apply;
		logic [ACC_W-1:0] code;
		logic             changed;
	} op_t;

endpackage

/* design/ansi_sgr_stream_filter.sv */
// top level of the ansi sgr stream filter
// an accepted byte is written into the queue, then into the output register
// throughput: one byte per cycle while the queue is not full; the front parses
// in the accept cycle; the back applies the style as the queue head is registered
// reset: asynchronous arst_n clears parser phase, style, queue and output valid;
// max_escape_length returns to 20
module ansi_sgr_stream_filter import sgr_pkg::*; #(
	parameter int QueueDepth = SGR_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	// filtered stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] char_out, [8:7] font_weight, [9] italic_on,
	                               // [10] underline_on, [14:11] fore_colour,
	                               // [18:15] back_colour, [19] style_changed, [23:20] zero
	output logic        m_tuser,   // [0] char_valid
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] max_len_q;
	logic       take;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	op_t        front_op;
	op_t        head_op;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_ESC_LEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_ESC_LEN) begin
			max_len_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr[2] == REG_MAX_ESC_LEN) ? {24'd0, max_len_q} : 32'd0;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	sgr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_in (s_tdata),
		.max_len (max_len_q),
		.op      (front_op)
	);

	sgr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_op   (front_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	sgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_not_empty),
		.op       (head_op),
		.op_pop   (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* design/sgr_queue.sv */
// short request queue between the parser front and the style back
module sgr_queue import sgr_pkg::*; #(
	parameter int Depth = SGR_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output op_t  head_op
);

	localparam int PtrW = (Depth > 2) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	op_t            slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head_op   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/sgr_front.sv */
// escape parser: tracks sequence phase and parameter value, emits one request per byte
module sgr_front import sgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	input  logic [7:0] max_len,
	output op_t        op
);

	phase_t           phase_q, phase_d;
	logic [7:0]       offset_q, offset_d;
	logic [ACC_W-1:0] acc_q, acc_d;

	logic             is_digit;
	logic             too_long;
	logic [13:0]      acc_next;

	// accumulator times ten plus the digit
	assign is_digit = (byte_in >= DIGIT_LO) && (byte_in <= DIGIT_HI);
	assign too_long = (offset_q >= max_len);
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ 14'(byte_in - DIGIT_LO);

	// next phase and request
	always_comb begin
		phase_d       = phase_q;
		offset_d      = offset_q;
		acc_d         = acc_q;
		op.char_valid = 1'b0;
		op.ch         = '0;
		op.apply      = 1'b0;
		op.code       = acc_q;
		op.changed    = 1'b0;
		case (phase_q)
			PH_ESC: begin
				if (byte_in == CH_OPEN) begin
					phase_d  = PH_PARAMS;
					offset_d = 8'd1;
					acc_d    = '0;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_PARAMS: begin
				if (is_digit) begin
					acc_d = (acc_next > 14'(ACC_MAX)) ? ACC_MAX : acc_next[ACC_W-1:0];
				end else if (byte_in == CH_END) begin
					op.apply   = 1'b1;
					op.changed = 1'b1;
					phase_d    = PH_IDLE;
				end else if (byte_in == CH_SEP) begin
					op.apply = 1'b1;
					acc_d    = '0;
				end else begin
					phase_d = PH_IDLE;
				end
				// length limit for bytes that keep the sequence open
				if (phase_d == PH_PARAMS) begin
					if (too_long) begin
						phase_d = PH_IDLE;
					end else begin
						offset_d = offset_q + 8'd1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (byte_in == CH_ESC) begin
					phase_d  = PH_ESC;
					offset_d = '0;
				end else if (byte_in != 8'd0 && !byte_in[7]) begin
					op.char_valid = 1'b1;
					op.ch         = byte_in[6:0];
				end
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			offset_q <= '0;
			acc_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			acc_q    <= acc_d;
		end
	end

endmodule

/* design/sgr_back.sv */
// style keeper: applies sgr codes and holds the output register
`include "assert_macros.svh"
module sgr_back import sgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  op_t         op,
	output logic        op_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tuser
);

	logic [1:0] weight_q, weight_d;
	logic       italic_q, italic_d;
	logic       uline_q, uline_d;
	logic [3:0] fore_q, fore_d;
	logic [3:0] back_q, back_d;

	logic       out_valid_q;
	logic       char_valid_q;
	logic [6:0] ch_q;
	logic       changed_q;

	assign op_pop = op_valid && (!out_valid_q || m_tready);

	// style update from one code
	always_comb begin
		weight_d = weight_q;
		italic_d = italic_q;
		uline_d  = uline_q;
		fore_d   = fore_q;
		back_d   = back_q;
		if (op.apply) begin
			case (op.code) inside
				SGR_RESET: begin
					weight_d = WEIGHT_NORMAL;
					italic_d = 1'b0;
					uline_d  = 1'b0;
					fore_d   = '0;
					back_d   = '0;
				end
				SGR_BOLD:      weight_d = WEIGHT_BOLD;
				SGR_FAINT:     weight_d = WEIGHT_FAINT;
				SGR_ITALIC:    italic_d = 1'b1;
				SGR_ULINE:     uline_d  = 1'b1;
				SGR_NORMAL:    weight_d = WEIGHT_NORMAL;
				SGR_NO_ITALIC: italic_d = 1'b0;
				SGR_NO_ULINE:  uline_d  = 1'b0;
				[SGR_FG_LO:SGR_FG_HI]: fore_d = 4'(op.code - (SGR_FG_LO - 10'd1));
				[SGR_BG_LO:SGR_BG_HI]: back_d = 4'(op.code - (SGR_BG_LO - 10'd1));
				default: ;
			endcase
		end
	end

	// style state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_NORMAL;
			italic_q <= 1'b0;
			uline_q  <= 1'b0;
			fore_q   <= '0;
			back_q   <= '0;
		end else if (op_pop) begin
			weight_q <= weight_d;
			italic_q <= italic_d;
			uline_q  <= uline_d;
			fore_q   <= fore_d;
			back_q   <= back_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (op_pop) begin
			char_valid_q <= op.char_valid;
			ch_q         <= op.ch;
			changed_q    <= op.changed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = char_valid_q;
	assign m_tdata  = {4'b0000, changed_q, back_q, fore_q, uline_q, italic_q,
		weight_q, ch_q};

	`ASSERT_NEVER(a_weight_code, clk, arst_n, weight_q == 2'd3, "weight holds an unused code")
	`ASSERT_NEVER(a_fore_range, clk, arst_n, fore_q > 4'd8, "foreground out of range")
	`ASSERT_NEVER(a_back_range, clk, arst_n, back_q > 4'd8, "background out of range")
	`ASSERT_PROP(a_change_no_char, clk, arst_n,
		(out_valid_q && changed_q) |-> !char_valid_q, "style change also carries a character")

endmodule
